/* rtl/edfm_pkg.sv */
// Shared types and constants for the edit distance fuzzy matcher.
package edfm_pkg;

    localparam int MaxQuery     = 32;
    localparam int MaxCandidate = 255;
    localparam int QIdxW        = $clog2(MaxQuery);
    localparam int QLenW        = $clog2(MaxQuery + 1);

    localparam logic [7:0] DistCap = 8'd255;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_QBYTE  = 2'd1,
        CMD_CBYTE  = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  distance;
        logic        is_match;
        logic [15:0] candidate_number;
        logic        truncated;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_query;
        logic append_query;
        logic restart;
        logic feed_start;
        logic feed_step;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic feed_last;
        logic cand_full;
    } t_dp_status;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == DistCap) ? DistCap : v + 8'd1;
    endfunction

endpackage

/* rtl/edfm_datapath.sv */
// Datapath: query memory, distance column, counters and result register.
module edfm_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    input  edfm_pkg::t_in_item    i_item,
    input  edfm_pkg::t_dp_cmd     i_cmd,
    output edfm_pkg::t_dp_status  o_status,
    output logic                  o_result_valid,
    output edfm_pkg::t_out_item   o_result
);
    import edfm_pkg::*;

    // Entry k holds the distance for query prefix k + 1; the empty prefix equals r_clen.
    logic [7:0]       r_qmem [MaxQuery];
    logic [7:0]       r_col  [MaxQuery];
    logic [QLenW-1:0] r_qlen;
    logic [QLenW-1:0] r_idx;
    logic [7:0]       r_diag;
    logic [7:0]       r_up;
    logic [7:0]       r_char;
    logic [7:0]       r_qbyte;
    logic [7:0]       r_clen;
    logic [15:0]      r_count;
    logic             r_cut;
    logic             r_qcut;
    logic [7:0]       r_limit;
    logic             r_valid;
    t_out_item        r_result;

    logic [7:0]       n_cell;
    logic [7:0]       w_m;
    logic [7:0]       w_old;
    logic [7:0]       w_fin;
    logic [QLenW-1:0] w_oidx;
    logic [QLenW-1:0] w_fidx;

    assign w_oidx = r_idx - QLenW'(1);
    assign w_fidx = r_qlen - QLenW'(1);
    assign w_old  = r_col[w_oidx[QIdxW-1:0]];
    assign w_fin  = (r_qlen == '0) ? r_clen : r_col[w_fidx[QIdxW-1:0]];

    always_comb begin
        w_m = (w_old < r_up) ? w_old : r_up;
        w_m = (w_m < r_diag) ? w_m : r_diag;
        n_cell = (r_qbyte == r_char) ? r_diag : sat_inc(w_m);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append_query && r_qlen < QLenW'(MaxQuery)) begin
            r_qmem[r_qlen[QIdxW-1:0]] <= i_item.char_code;
        end
        if (i_cmd.feed_start) begin
            r_qbyte <= r_qmem[0];
        end else if (i_cmd.feed_step) begin
            r_qbyte <= r_qmem[r_idx[QIdxW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MaxQuery; i++) r_col[i] <= 8'(i + 1);
            r_qlen   <= '0;
            r_idx    <= '0;
            r_clen   <= '0;
            r_count  <= '0;
            r_cut    <= 1'b0;
            r_qcut   <= 1'b0;
            r_limit  <= 8'd3;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (i_cmd.clear_query) begin
                r_qlen  <= '0;
                r_count <= '0;
                r_qcut  <= 1'b0;
            end
            if (i_cmd.append_query) begin
                if (r_qlen < QLenW'(MaxQuery)) r_qlen <= r_qlen + QLenW'(1);
                else r_qcut <= 1'b1;
            end
            if (i_cmd.feed_start) begin
                if (r_clen == 8'(MaxCandidate)) begin
                    r_cut <= 1'b1;
                end else begin
                    r_char <= i_item.char_code;
                    r_diag <= r_clen;
                    r_up   <= sat_inc(r_clen);
                    r_clen <= r_clen + 8'd1;
                    r_idx  <= QLenW'(1);
                end
            end
            if (i_cmd.feed_step) begin
                r_col[w_oidx[QIdxW-1:0]] <= n_cell;
                r_diag                   <= w_old;
                r_up                     <= n_cell;
                r_idx                    <= r_idx + QLenW'(1);
            end
            if (i_cmd.emit) begin
                r_result.distance         <= w_fin;
                r_result.is_match         <= w_fin < r_limit;
                r_result.candidate_number <= r_count;
                r_result.truncated        <= r_cut | r_qcut;
                r_count                   <= r_count + 16'd1;
            end
            if (i_cmd.restart) begin
                for (int i = 0; i < MaxQuery; i++) r_col[i] <= 8'(i + 1);
                r_clen <= '0;
                r_cut  <= 1'b0;
            end
        end
    end

    assign o_status.feed_last = (r_idx >= r_qlen);
    assign o_status.cand_full = (r_clen == 8'(MaxCandidate));
    assign o_result_valid     = r_valid;
    assign o_result           = r_result;

endmodule

/* rtl/edfm_ctrl.sv */
// Controller: decodes commands and sequences the column update.
module edfm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  edfm_pkg::t_in_item    i_item,
    input  edfm_pkg::t_dp_status  i_status,
    output edfm_pkg::t_dp_cmd     o_cmd,
    output logic                  busy
);
    import edfm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FEED, S_PRIME} t_state;
    t_state r_state;
    logic   w_take;
    t_cmd   w_op;

    assign w_take = start && (r_state == S_IDLE);
    assign w_op   = t_cmd'(i_item.command);

    always_comb begin
        o_cmd = '0;
        if (w_take) begin
            unique case (w_op)
                CMD_CLEAR: begin
                    o_cmd.clear_query = 1'b1;
                    o_cmd.restart     = 1'b1;
                end
                CMD_QBYTE: begin
                    o_cmd.append_query = 1'b1;
                    o_cmd.restart      = 1'b1;
                end
                CMD_CBYTE: o_cmd.feed_start = 1'b1;
                CMD_END: begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.restart = 1'b1;
                end
                default: o_cmd = '0;
            endcase
        end
        if (r_state == S_FEED) o_cmd.feed_step = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_take && w_op == CMD_CBYTE && !i_status.cand_full)
                    r_state <= S_PRIME;
                S_PRIME: r_state <= S_FEED;
                S_FEED: if (i_status.feed_last) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* rtl/edit_distance_fuzzy_matcher_unit.sv */
// Top level of the streaming Levenshtein edit distance matcher.
// Usage:
//   Drive i_item (command and char_code) and raise start; the transaction
//   is taken at a clock edge where start is high and busy is low.
//   Commands: clear query, append query byte, candidate byte, end of
//   candidate. Only end of candidate produces a result.
//   A result appears on o_result for one cycle with o_result_valid high,
//   in the cycle after the end transaction; the receiver cannot stall.
//   Clear, append and end never make the unit busy. A candidate byte walks the
//   distance column one query position per cycle through one shared cell,
//   with busy high until the walk ends (busy stays low when the candidate
//   is already full).
//   match_limit is written with i_cfg_we / i_cfg_data while idle.
//   After reset: empty query, column holds 1..32, limit 3, count 0.
//   Query bytes beyond 32 and candidate bytes beyond 255 are dropped and
//   set the truncated flag of the result.
module edit_distance_fuzzy_matcher_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  edfm_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_result_valid,
    output edfm_pkg::t_out_item  o_result
);
    import edfm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    edfm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    edfm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
